### hw/rtl/crpb_pkg.sv
// Shared types, constants and the control store for the circle raster block.
// Used by crpb_seq, crpb_dp and the top level; depends on nothing else.
`timescale 1ns / 1ps

package crpb_pkg;

  // Screen geometry
  localparam int SCREEN_WIDTH = 128;
  localparam int PAGE_COUNT   = 8;
  localparam int ROW_COUNT    = PAGE_COUNT * 8;
  localparam int BUF_BYTES    = SCREEN_WIDTH * PAGE_COUNT;
  localparam int AW           = $clog2(BUF_BYTES);

  // Coordinate and error-term widths (signed)
  localparam int CW = 10;
  localparam int EW = 12;

  // Step counter width
  localparam int UW = 5;

  // Request opcodes
  localparam logic [1:0] OP_CIRCLE = 2'd0;
  localparam logic [1:0] OP_PIXEL  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  // Point selects for the address generator
  localparam logic [2:0] PT_C0   = 3'd0;
  localparam logic [2:0] PT_C1   = 3'd1;
  localparam logic [2:0] PT_C2   = 3'd2;
  localparam logic [2:0] PT_C3   = 3'd3;
  localparam logic [2:0] PT_PIX  = 3'd4;
  localparam logic [2:0] PT_READ = 3'd5;

  // Sequencer branch conditions
  localparam logic [2:0] C_NEXT = 3'd0;  // advance
  localparam logic [2:0] C_JMP  = 3'd1;  // jump to target
  localparam logic [2:0] C_DISP = 3'd2;  // wait for a request, dispatch on opcode
  localparam logic [2:0] C_LOOP = 3'd3;  // jump to target while the circle loop runs
  localparam logic [2:0] C_CLR  = 3'd4;  // hold until the clear sweep ends, then target
  localparam logic [2:0] C_WAIT = 3'd5;  // hold while the output slot is busy, then target

  // Program step addresses
  localparam logic [UW-1:0] S_CLR   = 5'd0;
  localparam logic [UW-1:0] S_IDLE  = 5'd1;
  localparam logic [UW-1:0] S_CINIT = 5'd2;
  localparam logic [UW-1:0] S_RD0   = 5'd3;
  localparam logic [UW-1:0] S_WR0   = 5'd4;
  localparam logic [UW-1:0] S_RD1   = 5'd5;
  localparam logic [UW-1:0] S_WR1   = 5'd6;
  localparam logic [UW-1:0] S_RD2   = 5'd7;
  localparam logic [UW-1:0] S_WR2   = 5'd8;
  localparam logic [UW-1:0] S_RD3   = 5'd9;
  localparam logic [UW-1:0] S_WR3   = 5'd10;
  localparam logic [UW-1:0] S_UPD   = 5'd11;
  localparam logic [UW-1:0] S_DONE  = 5'd12;
  localparam logic [UW-1:0] S_PRD   = 5'd13;
  localparam logic [UW-1:0] S_PWR   = 5'd14;
  localparam logic [UW-1:0] S_RRD   = 5'd15;
  localparam logic [UW-1:0] S_RCAP  = 5'd16;

  typedef struct packed {
    logic       load;  // capture request fields
    logic       init;  // start circle loop
    logic       rd;    // address a pixel and read its byte
    logic [2:0] pt;    // which point to address
    logic       wr;    // modify and store the byte, count
    logic       upd;   // advance circle loop variables
    logic       cap;   // capture read byte into result
    logic       clr;   // clear sweep write
    logic       done;  // hand the result to the output register
  } dp_ctrl_t;

  typedef struct packed {
    dp_ctrl_t        ctl;
    logic [2:0]      cond;
    logic [UW-1:0]   target;
  } ucode_t;

  typedef struct packed {
    logic clr_last;
    logic loop_more;
    logic out_busy;
  } dp_stat_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k] = v[7-k];
    end
    return r;
  endfunction

  function automatic logic [UW-1:0] dispatch(input logic [1:0] op);
    logic [UW-1:0] s;
    case (op)
      OP_CIRCLE: s = S_CINIT;
      OP_PIXEL:  s = S_PRD;
      OP_READ:   s = S_RRD;
      OP_NOP:    s = S_DONE;
      default:   s = S_DONE;
    endcase
    return s;
  endfunction

  function automatic ucode_t ucode_rom(input logic [UW-1:0] a);
    ucode_t w;
    w = '0;
    case (a)
      S_CLR: begin
        w.ctl.clr = 1'b1; w.cond = C_CLR; w.target = S_IDLE;
      end
      S_IDLE: begin
        w.ctl.load = 1'b1; w.cond = C_DISP;
      end
      S_CINIT: begin
        w.ctl.init = 1'b1; w.cond = C_NEXT;
      end
      S_RD0: begin
        w.ctl.rd = 1'b1; w.ctl.pt = PT_C0; w.cond = C_NEXT;
      end
      S_RD1: begin
        w.ctl.rd = 1'b1; w.ctl.pt = PT_C1; w.cond = C_NEXT;
      end
      S_RD2: begin
        w.ctl.rd = 1'b1; w.ctl.pt = PT_C2; w.cond = C_NEXT;
      end
      S_RD3: begin
        w.ctl.rd = 1'b1; w.ctl.pt = PT_C3; w.cond = C_NEXT;
      end
      S_WR0, S_WR1, S_WR2, S_WR3: begin
        w.ctl.wr = 1'b1; w.cond = C_NEXT;
      end
      S_UPD: begin
        w.ctl.upd = 1'b1; w.cond = C_LOOP; w.target = S_RD0;
      end
      S_DONE: begin
        w.ctl.done = 1'b1; w.cond = C_WAIT; w.target = S_IDLE;
      end
      S_PRD: begin
        w.ctl.rd = 1'b1; w.ctl.pt = PT_PIX; w.cond = C_NEXT;
      end
      S_PWR: begin
        w.ctl.wr = 1'b1; w.cond = C_JMP; w.target = S_DONE;
      end
      S_RRD: begin
        w.ctl.rd = 1'b1; w.ctl.pt = PT_READ; w.cond = C_NEXT;
      end
      S_RCAP: begin
        w.ctl.cap = 1'b1; w.cond = C_JMP; w.target = S_DONE;
      end
      default: begin
        w.cond = C_JMP; w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/crpb_seq.sv
// Microcode sequencer: step counter, control store lookup and branch logic.
// Depends on crpb_pkg.
`timescale 1ns / 1ps

module crpb_seq import crpb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] opcode,
  input  dp_stat_t   stat,
  output dp_ctrl_t   ctl,
  output logic       in_stall
);

  logic [UW-1:0] upc;
  logic [UW-1:0] upc_next;
  ucode_t        word;

  assign word     = ucode_rom(upc);
  assign ctl      = word.ctl;
  assign in_stall = (word.cond != C_DISP);

  always_comb begin
    case (word.cond)
      C_NEXT:  upc_next = UW'(upc + 1'b1);
      C_JMP:   upc_next = word.target;
      C_DISP:  upc_next = in_valid ? dispatch(opcode) : upc;
      C_LOOP:  upc_next = stat.loop_more ? word.target : UW'(upc + 1'b1);
      C_CLR:   upc_next = stat.clr_last ? word.target : upc;
      C_WAIT:  upc_next = stat.out_busy ? upc : word.target;
      default: upc_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= S_CLR;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

### hw/rtl/crpb_dp.sv
// Datapath: request registers, circle loop variables, address generator,
// frame buffer memory with byte read-modify-write, counters and result register.
// Depends on crpb_pkg.
`timescale 1ns / 1ps

module crpb_dp import crpb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  dp_ctrl_t   ctl,
  input  logic       in_valid,
  input  logic [6:0] center_x,
  input  logic [5:0] center_y,
  input  logic [5:0] radius,
  input  logic       clear_pixels,
  input  logic [2:0] read_page,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       out_stall,
  output dp_stat_t   stat,
  output logic       out_valid,
  output logic [7:0] read_data,
  output logic [9:0] pixels_written,
  output logic [9:0] pixels_clipped
);

  localparam logic signed [CW-1:0] SW_S  = CW'(SCREEN_WIDTH);
  localparam logic signed [CW-1:0] RC_S  = CW'(ROW_COUNT);
  localparam logic signed [EW-1:0] ONE_E = EW'(1);

  // Request registers
  logic [6:0] cx_q;
  logic [5:0] cy_q;
  logic [5:0] r_q;
  logic       clr_q;
  logic [2:0] pg_q;
  logic       flip_q;

  // Circle loop state
  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [EW-1:0] err;

  // Pixel access registers
  logic [AW-1:0] addr_q;
  logic [2:0]    bit_q;
  logic          on_q;
  logic [AW-1:0] clr_cnt;

  // Result accumulation
  logic [7:0] rd_q;
  logic [9:0] wr_cnt;
  logic [9:0] clip_cnt;

  logic [7:0] mem [BUF_BYTES];
  logic [7:0] rdata;

  // Loop update
  logic signed [EW-1:0] xe, ye, x1, e1, y1, e2;
  logic                 step_x, step_y;

  always_comb begin
    xe     = EW'(x);
    ye     = EW'(y);
    step_x = (err <= xe);
    x1     = step_x ? xe + ONE_E : xe;
    e1     = step_x ? err + (x1 <<< 1) + ONE_E : err;
    step_y = (err > ye) || (e1 > x1);
    y1     = step_y ? ye + ONE_E : ye;
    e2     = step_y ? e1 + (y1 <<< 1) + ONE_E : e1;
  end

  // Address generator
  logic signed [CW-1:0] cxs, cys, col, row;
  logic                 on_scr;
  logic [AW-1:0]        addr_c;

  assign cxs = CW'(cx_q);
  assign cys = CW'(cy_q);

  always_comb begin
    case (ctl.pt)
      PT_C0:   begin col = cxs - x; row = cys + y; end
      PT_C1:   begin col = cxs - y; row = cys - x; end
      PT_C2:   begin col = cxs + x; row = cys - y; end
      PT_C3:   begin col = cxs + y; row = cys + x; end
      PT_READ: begin col = cxs;     row = CW'({pg_q, 3'b000}); end
      default: begin col = cxs;     row = cys; end
    endcase
    on_scr = (col >= 0) && (col < SW_S) && (row >= 0) && (row < RC_S);
    addr_c = AW'(AW'(row[CW-2:3]) * AW'(SCREEN_WIDTH)) + AW'(col[CW-2:0]);
  end

  // Byte modify
  logic [7:0] mask;
  logic [7:0] mod_b;
  logic [7:0] mod_byte;

  assign mask     = 8'h01 << bit_q;
  assign mod_b    = clr_q ? (rdata & ~mask) : (rdata | mask);
  assign mod_byte = flip_q ? rev8(mod_b) : mod_b;

  // Frame buffer
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;

  assign mem_we = ctl.clr || (ctl.wr && on_q);
  assign mem_wa = ctl.clr ? clr_cnt : addr_q;
  assign mem_wd = ctl.clr ? 8'h00 : mod_byte;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata <= mem[addr_c];
  end

  assign stat.clr_last  = (clr_cnt == AW'(BUF_BYTES - 1));
  assign stat.loop_more = y1[EW-1];
  assign stat.out_busy  = out_valid && out_stall;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      flip_q    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.clr) begin
        clr_cnt <= AW'(clr_cnt + 1'b1);
      end
      if (cfg_we) begin
        flip_q <= cfg_wdata;
      end
      if (ctl.done && !stat.out_busy) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (ctl.load && in_valid) begin
      cx_q     <= center_x;
      cy_q     <= center_y;
      r_q      <= radius;
      clr_q    <= clear_pixels;
      pg_q     <= read_page;
      rd_q     <= 8'h00;
      wr_cnt   <= '0;
      clip_cnt <= '0;
    end
    if (ctl.init) begin
      x   <= '0;
      y   <= CW'(0) - CW'(r_q);
      err <= EW'(2) - (EW'(r_q) << 1);
    end
    if (ctl.upd) begin
      x   <= x1[CW-1:0];
      y   <= y1[CW-1:0];
      err <= e2;
    end
    if (ctl.rd) begin
      addr_q <= addr_c;
      bit_q  <= row[2:0];
      on_q   <= on_scr;
    end
    if (ctl.wr) begin
      if (on_q) begin
        wr_cnt <= wr_cnt + 1'b1;
      end else begin
        clip_cnt <= clip_cnt + 1'b1;
      end
    end
    if (ctl.cap) begin
      rd_q <= on_q ? rdata : 8'h00;
    end
    if (ctl.done && !stat.out_busy) begin
      read_data      <= rd_q;
      pixels_written <= wr_cnt;
      pixels_clipped <= clip_cnt;
    end
  end

endmodule

### hw/rtl/circle_raster_into_page_buffer.sv
// Top level of the circle raster block: page-organized monochrome frame buffer
// with circle, pixel and byte-read requests. Depends on crpb_pkg, crpb_seq, crpb_dp.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request: opcode, center_x,
//   center_y, radius, clear_pixels, read_page. A request is taken at a clock edge
//   with in_valid high and in_stall low. Output channel (out_valid / out_stall)
//   returns one result per request: read_data, pixels_written, pixels_clipped.
//   cfg_we / cfg_wdata write flip_mode; write it only while the block is idle.
//   Sequencing: a microcoded sequencer runs one request at a time. Each pixel is a
//   byte read then a byte write; each circle loop step is 4 pixels plus one
//   update. A circle of radius r runs at most 2r+1 steps.
//   Reset: the frame buffer is cleared by a sweep over all 1024 bytes, one byte
//   per cycle; in_stall stays high until it is done. flip_mode returns to 0.
//   Output stall: the result sits in an output register, so the next request is
//   taken while a result waits; a second result holds the sequencer until the
//   first one is taken.
`timescale 1ns / 1ps

module circle_raster_into_page_buffer import crpb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] opcode,
  input  logic [6:0] center_x,
  input  logic [5:0] center_y,
  input  logic [5:0] radius,
  input  logic       clear_pixels,
  input  logic [2:0] read_page,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic [9:0] pixels_written,
  output logic [9:0] pixels_clipped
);

  dp_ctrl_t ctl;
  dp_stat_t stat;

  // Sequencer: step counter over the control store, dispatch on opcode
  crpb_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .stat     (stat),
    .ctl      (ctl),
    .in_stall (in_stall)
  );

  // Datapath: loop variables, addressing, frame buffer, counters, result register
  crpb_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .in_valid       (in_valid),
    .center_x       (center_x),
    .center_y       (center_y),
    .radius         (radius),
    .clear_pixels   (clear_pixels),
    .read_page      (read_page),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_stall      (out_stall),
    .stat           (stat),
    .out_valid      (out_valid),
    .read_data      (read_data),
    .pixels_written (pixels_written),
    .pixels_clipped (pixels_clipped)
  );

endmodule

### hw/rtl/crpb_chk.sv
// Port-level checker for the circle raster block, bound to the top level.
// Depends on circle_raster_into_page_buffer port names only.
`timescale 1ns / 1ps

module crpb_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] read_data,
  input logic [9:0] pixels_written,
  input logic [9:0] pixels_clipped
);

  // Clear sweep follows reset: no request taken right after it
  a_clear_after_reset: assert property (@(posedge clk) rst |=> in_stall)
    else $error("request taken during frame buffer clear");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data)
      && $stable(pixels_written) && $stable(pixels_clipped))
    else $error("stalled result changed");

  // A read result carries no pixel counts
  a_read_no_counts: assert property (@(posedge clk) disable iff (rst)
    out_valid && (read_data != 8'h00) |-> (pixels_written == 10'd0)
      && (pixels_clipped == 10'd0))
    else $error("read result with pixel counts");

  // A draw result carries no read byte
  a_draw_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((pixels_written != 10'd0) || (pixels_clipped != 10'd0))
      |-> (read_data == 8'h00))
    else $error("draw result with read data");

endmodule

bind circle_raster_into_page_buffer crpb_chk u_crpb_chk (.*);

### test/tb.sv
// Self-checking bench for circle_raster_into_page_buffer: draws circles and pixels,
// reads bytes back and checks every result against a local copy of the page buffer.
// Depends on crpb_pkg for geometry and opcodes, and on the block's RTL.
`timescale 1ns / 1ps

module tb;
  import crpb_pkg::*;

  // What the sender queue can hold: a request, a flip_mode write, or a pause
  // that holds the sender until every result is back.
  typedef enum logic [1:0] {
    ITEM_REQUEST,
    ITEM_FLIP,
    ITEM_DRAIN
  } item_kind_t;

  typedef struct packed {
    item_kind_t kind;
    logic [1:0] op;
    logic [6:0] cx;
    logic [5:0] cy;
    logic [5:0] rad;
    logic       clr;
    logic [2:0] page;
    logic       flip;
  } queued_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic [9:0] written;
    logic [9:0] clipped;
  } raster_result_t;

  // Cycles with nothing outstanding before a flip_mode write goes out.
  localparam int SETTLE_CYCLES = 4;
  // Upper bound of the sender and receiver gaps per item.
  localparam int MAX_GAP = 17;
  // Random part: phases, each ending with a flip_mode write.
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 92;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] opcode = OP_NOP;
  logic [6:0] center_x = '0;
  logic [5:0] center_y = '0;
  logic [5:0] radius = '0;
  logic       clear_pixels = 1'b0;
  logic [2:0] read_page = '0;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b1;
  logic [7:0] read_data;
  logic [9:0] pixels_written;
  logic [9:0] pixels_clipped;

  circle_raster_into_page_buffer dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .center_x       (center_x),
    .center_y       (center_y),
    .radius         (radius),
    .clear_pixels   (clear_pixels),
    .read_page      (read_page),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .read_data      (read_data),
    .pixels_written (pixels_written),
    .pixels_clipped (pixels_clipped)
  );

  // Sender queue, filled once at time zero.
  queued_item_t   request_queue[$];
  // Results still owed by the block, oldest first.
  raster_result_t raster_results_due[$];

  // Local copy of the page buffer and of flip_mode.
  logic [7:0] page_buf [0:BUF_BYTES-1];
  logic       flip_on = 1'b0;
  int         plotted;
  int         clipped;

  int   error_count = 0;
  int   idle_cycles = 0;
  logic took_req = 1'b0;
  logic took_res = 1'b0;
  logic stim_done = 1'b0;

  // Sender and receiver pacing state.
  int gap_left = 0;
  int tx_burst = 0;
  int hold_left = 0;
  int rx_burst = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Set or clear one pixel by byte read-modify-write; skip and count it when it
  // lies off screen. With flip on, reverse the whole stored byte.
  function automatic void plot_pixel(int col, int row, logic clr);
    int         idx;
    logic [7:0] b;
    logic [7:0] rev;
    if (col < 0 || col >= SCREEN_WIDTH || row < 0 || row >= ROW_COUNT) begin
      clipped++;
      return;
    end
    idx = (row / 8) * SCREEN_WIDTH + col;
    b = page_buf[idx];
    b[row % 8] = ~clr;
    if (flip_on) begin
      for (int k = 0; k < 8; k++) rev[k] = b[7-k];
      b = rev;
    end
    page_buf[idx] = b;
    plotted++;
  endfunction

  // Apply one request to the local buffer and return the result it owes.
  function automatic raster_result_t render_request(logic [1:0] op, logic [6:0] cx,
                                                     logic [5:0] cy, logic [5:0] r,
                                                     logic clr, logic [2:0] page);
    raster_result_t res;
    int ccol, crow, rad, x, y, err, prev;
    res = '0;
    plotted = 0;
    clipped = 0;
    ccol = cx;
    crow = cy;
    rad = r;
    case (op)
      OP_CIRCLE: begin
        // Integer circle walk: four mirrored points per step, repeats included.
        x = 0;
        y = -rad;
        err = 2 - 2 * rad;
        do begin
          plot_pixel(ccol - x, crow + y, clr);
          plot_pixel(ccol - y, crow - x, clr);
          plot_pixel(ccol + x, crow - y, clr);
          plot_pixel(ccol + y, crow + x, clr);
          prev = err;
          if (prev <= x) begin
            x++;
            err += x * 2 + 1;
          end
          if (prev > y || err > x) begin
            y++;
            err += y * 2 + 1;
          end
        end while (y < 0);
      end
      OP_PIXEL: begin
        plot_pixel(ccol, crow, clr);
      end
      OP_READ: begin
        if (ccol < SCREEN_WIDTH && page < PAGE_COUNT)
          res.data = page_buf[page * SCREEN_WIDTH + ccol];
      end
      default: ;
    endcase
    res.written = plotted[9:0];
    res.clipped = clipped[9:0];
    return res;
  endfunction

  // Count one mismatch and print one line for it.
  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_request(input logic [1:0] op, input logic [6:0] cx,
                               input logic [5:0] cy, input logic [5:0] r,
                               input logic clr, input logic [2:0] page);
    queued_item_t it;
    it = '0;
    it.kind = ITEM_REQUEST;
    it.op = op;
    it.cx = cx;
    it.cy = cy;
    it.rad = r;
    it.clr = clr;
    it.page = page;
    request_queue.push_back(it);
  endtask

  task automatic queue_flip(input logic value);
    queued_item_t it;
    it = '0;
    it.kind = ITEM_FLIP;
    it.flip = value;
    request_queue.push_back(it);
  endtask

  task automatic queue_drain();
    queued_item_t it;
    it = '0;
    it.kind = ITEM_DRAIN;
    request_queue.push_back(it);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels and the config port at the rising edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_channels
    raster_result_t want;
    took_req <= !rst && in_valid && !in_stall;
    took_res <= !rst && out_valid === 1'b1 && !out_stall;
    if (!rst) begin
      // Track flip_mode as the block sees it.
      if (cfg_we)
        flip_on = cfg_wdata;
      // Predict every request the block takes.
      if (in_valid && !in_stall)
        raster_results_due.push_back(render_request(opcode, center_x, center_y, radius,
                                                    clear_pixels, read_page));
      // Match every result the block hands over against the oldest prediction.
      if (out_valid === 1'b1 && !out_stall) begin
        if (raster_results_due.size() == 0) begin
          report_mismatch("result with no request outstanding", read_data, 0);
        end else begin
          want = raster_results_due.pop_front();
          if (read_data !== want.data)
            report_mismatch("read_data", read_data, want.data);
          if (pixels_written !== want.written)
            report_mismatch("pixels_written", pixels_written, want.written);
          if (pixels_clipped !== want.clipped)
            report_mismatch("pixels_clipped", pixels_clipped, want.clipped);
        end
      end
    end
    // Count quiet cycles so config writes only land on an idle block.
    if (rst || raster_results_due.size() != 0 || out_valid !== 1'b0)
      idle_cycles = 0;
    else if (idle_cycles < 1000)
      idle_cycles++;
  end

  // ---------------------------------------------------------------------------
  // Request driver: change inputs at the falling edge, one assignment per signal.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_requests
    queued_item_t head;
    logic         valid_next;
    logic         we_next;
    logic         settled;
    valid_next = in_valid;
    we_next = 1'b0;
    settled = idle_cycles >= SETTLE_CYCLES && in_stall === 1'b0;
    // Hold a stalled request as it is; otherwise the channel is free.
    if (!rst && !(in_valid && !took_req)) begin
      valid_next = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (request_queue.size() == 0) begin
        stim_done <= 1'b1;
      end else begin
        head = request_queue[0];
        case (head.kind)
          ITEM_REQUEST: begin
            opcode       <= head.op;
            center_x     <= head.cx;
            center_y     <= head.cy;
            radius       <= head.rad;
            clear_pixels <= head.clr;
            read_page    <= head.page;
            valid_next = 1'b1;
            request_queue.delete(0);
            // Draw the gap after this request; now and then run a back-to-back stretch.
            if (tx_burst > 0) begin
              tx_burst--;
              gap_left = 0;
            end else begin
              gap_left = $urandom_range(0, MAX_GAP);
              if ($urandom_range(0, 19) == 0)
                tx_burst = $urandom_range(8, 30);
            end
          end
          ITEM_FLIP: begin
            // Write flip_mode only once everything owed has come back.
            if (settled) begin
              we_next = 1'b1;
              cfg_wdata <= head.flip;
              request_queue.delete(0);
            end
          end
          default: begin
            if (settled)
              request_queue.delete(0);
          end
        endcase
      end
    end
    in_valid <= valid_next;
    cfg_we <= we_next;
  end

  // ---------------------------------------------------------------------------
  // Result receiver: stall each result for a random number of cycles.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_stall
    if (took_res) begin
      if (rx_burst > 0) begin
        rx_burst--;
        hold_left = 0;
      end else begin
        hold_left = $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 19) == 0)
          rx_burst = $urandom_range(8, 30);
      end
    end
    out_stall <= hold_left > 0;
    // Spend the stall only while a result actually waits.
    if (out_valid === 1'b1 && hold_left > 0)
      hold_left--;
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int sel, t;
    int last_cx, last_cy, last_r;
    logic [1:0] op;
    logic [6:0] cx;
    logic [5:0] cy;
    logic [5:0] r;
    logic       clr;
    logic [2:0] page;

    for (int i = 0; i < BUF_BYTES; i++) page_buf[i] = '0;
    hold_left = $urandom_range(0, MAX_GAP);

    // Directed part: field extremes, every opcode, clipping, radius zero, flip.
    queue_flip(1'b0);
    queue_request(OP_PIXEL, 7'd0, 6'd0, 6'd0, 1'b0, 3'd0);
    queue_request(OP_PIXEL, 7'd127, 6'd63, 6'd63, 1'b0, 3'd7);
    queue_request(OP_READ, 7'd0, 6'd0, 6'd0, 1'b0, 3'd0);
    queue_request(OP_READ, 7'd127, 6'd63, 6'd63, 1'b1, 3'd7);
    queue_request(OP_PIXEL, 7'd0, 6'd0, 6'd0, 1'b1, 3'd0);
    queue_request(OP_READ, 7'd0, 6'd0, 6'd0, 1'b0, 3'd0);
    // Radius zero lands on the center four times.
    queue_request(OP_CIRCLE, 7'd64, 6'd32, 6'd0, 1'b0, 3'd0);
    queue_request(OP_READ, 7'd64, 6'd0, 6'd0, 1'b0, 3'd4);
    // Largest radius: most of the ring falls off screen.
    queue_request(OP_CIRCLE, 7'd64, 6'd32, 6'd63, 1'b0, 3'd0);
    queue_request(OP_CIRCLE, 7'd0, 6'd0, 6'd5, 1'b0, 3'd0);
    queue_request(OP_READ, 7'd5, 6'd0, 6'd0, 1'b0, 3'd0);
    queue_request(OP_CIRCLE, 7'd127, 6'd63, 6'd10, 1'b1, 3'd0);
    queue_request(OP_CIRCLE, 7'd64, 6'd32, 6'd0, 1'b1, 3'd0);
    queue_request(OP_READ, 7'd64, 6'd0, 6'd0, 1'b0, 3'd4);
    queue_request(OP_NOP, 7'd127, 6'd63, 6'd63, 1'b1, 3'd7);
    // Pause for every result, then flip on: the whole byte reverses per write.
    queue_drain();
    queue_flip(1'b1);
    queue_request(OP_PIXEL, 7'd5, 6'd3, 6'd0, 1'b0, 3'd0);
    queue_request(OP_PIXEL, 7'd5, 6'd3, 6'd0, 1'b0, 3'd0);
    queue_request(OP_READ, 7'd5, 6'd0, 6'd0, 1'b0, 3'd0);
    queue_request(OP_CIRCLE, 7'd20, 6'd20, 6'd3, 1'b0, 3'd0);
    queue_request(OP_READ, 7'd20, 6'd0, 6'd0, 1'b0, 3'd2);
    queue_flip(1'b0);

    // Random part: phases of mixed requests, flip_mode changed between phases.
    last_cx = 64;
    last_cy = 32;
    last_r = 4;
    for (int ph = 0; ph < PHASES; ph++) begin
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Randomize every field, then shape it by opcode.
        cx = 7'($urandom_range(0, 127));
        cy = 6'($urandom_range(0, 63));
        r = 6'($urandom_range(0, 63));
        page = 3'($urandom_range(0, 7));
        clr = $urandom_range(0, 3) == 0;
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
          op = OP_CIRCLE;
          // Keep most circles small; a few keep the full radius range.
          if ($urandom_range(0, 15) != 0)
            r = 6'($urandom_range(0, 12));
          last_cx = cx;
          last_cy = cy;
          last_r = r;
        end else if (sel < 60) begin
          op = OP_PIXEL;
        end else if (sel < 95) begin
          op = OP_READ;
          // Aim half the reads at the last circle so they see its ink.
          if ($urandom_range(0, 1) == 1) begin
            t = last_cx + $urandom_range(0, 2 * last_r) - last_r;
            cx = t[6:0];
            t = last_cy + $urandom_range(0, 2 * last_r) - last_r;
            page = t[5:3];
          end
        end else begin
          op = OP_NOP;
        end
        queue_request(op, cx, cy, r, clr, page);
        if ($urandom_range(0, 49) == 0)
          queue_drain();
      end
      queue_flip(ph % 2 == 0 ? 1'b1 : 1'($urandom_range(0, 1)));
    end

    // Release reset; the block then clears its buffer on its own.
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Wait for the sender to run dry and for every owed result.
    do @(posedge clk);
    while (!(stim_done && raster_results_due.size() == 0));
    // Give a stray extra result time to show up.
    repeat (50) @(posedge clk);

    if (error_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #40_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### files.f
hw/rtl/crpb_pkg.sv
hw/rtl/crpb_seq.sv
hw/rtl/crpb_dp.sv
hw/rtl/circle_raster_into_page_buffer.sv
hw/rtl/crpb_chk.sv
test/tb.sv
